@@ src/sti_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants, status codes and controller/datapath interface types
// for the sorted table. No dependencies.
package sti_pkg;

    // Table depth and derived widths.
    localparam int CAPACITY    = 16;
    localparam int IDX_W       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W       = $clog2(CAPACITY + 1);

    // Fixed field widths.
    localparam int KEY_W       = 32;
    localparam int ID_W        = 16;
    localparam int STATUS_W    = 2;
    localparam int COUNT_OUT_W = 5;

    // Command codes.
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_FIND   = 1'b1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_INSERTED  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FOUND     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;     // capture the command and restart the scan
        logic advance;  // step the scan to the next entry
        logic commit;   // finish the command and register its result
    } sti_ctl_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_find;  // latched command is a find
        logic full;     // table holds CAPACITY entries
        logic at_end;   // scan index has reached the entry count
        logic hit;      // entry under the scan index decides the command
    } sti_stat_t;

endpackage

@@ src/sti_ctrl.sv @@
`timescale 1ns / 1ps
// Controller for the sorted table: sequences the entry scan of one command.
// Depends on sti_pkg.
module sti_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  sti_pkg::sti_stat_t stat,
    output sti_pkg::sti_ctl_t  ctl,
    output logic              busy
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_SCAN = 1'b1;

    logic state_reg;
    logic state_next;

    always_comb
    begin
        ctl        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    ctl.load   = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                // A full table ends an insert at once; otherwise the scan stops
                // at the deciding entry or past the last entry.
                priority if ((stat.full && !stat.is_find) || stat.at_end || stat.hit)
                begin
                    ctl.commit = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    ctl.advance = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg == S_SCAN);

endmodule

@@ src/sti_datapath.sv @@
`timescale 1ns / 1ps
// Datapath for the sorted table: entry storage, scan index, key and id
// compare, shift-insert and the result registers. Depends on sti_pkg.
module sti_datapath (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  sti_pkg::sti_ctl_t                     ctl,
    output sti_pkg::sti_stat_t                    stat,
    input  logic                                  cmd,
    input  logic [sti_pkg::ID_W-1:0]              item_id,
    input  logic signed [sti_pkg::KEY_W-1:0]      sort_key,
    input  logic                                  cfg_wr,
    input  logic                                  cfg_descending,
    output logic                                  done,
    output logic [sti_pkg::STATUS_W-1:0]          status,
    output logic signed [sti_pkg::KEY_W-1:0]      matched_key,
    output logic [sti_pkg::COUNT_OUT_W-1:0]       entry_count
);

    // Table storage, one cell per entry.
    logic signed [sti_pkg::KEY_W-1:0] keys_reg [sti_pkg::CAPACITY];
    logic        [sti_pkg::ID_W-1:0]  ids_reg  [sti_pkg::CAPACITY];

    // Latched command.
    logic                              cmd_reg;
    logic [sti_pkg::ID_W-1:0]          id_reg;
    logic signed [sti_pkg::KEY_W-1:0]  key_reg;

    // Control state.
    logic [sti_pkg::CNT_W-1:0] idx_reg;
    logic [sti_pkg::CNT_W-1:0] idx_next;
    logic [sti_pkg::CNT_W-1:0] count_reg;
    logic [sti_pkg::CNT_W-1:0] count_next;
    logic                      desc_reg;
    logic                      done_reg;

    // Result registers.
    logic [sti_pkg::STATUS_W-1:0]        status_reg;
    logic [sti_pkg::STATUS_W-1:0]        status_next;
    logic signed [sti_pkg::KEY_W-1:0]    matched_key_reg;
    logic signed [sti_pkg::KEY_W-1:0]    matched_key_next;
    logic [sti_pkg::COUNT_OUT_W-1:0]     entry_count_reg;
    logic [sti_pkg::COUNT_OUT_W-1:0]     entry_count_next;

    logic [sti_pkg::IDX_W-1:0]         idx_sel;
    logic signed [sti_pkg::KEY_W-1:0]  cur_key;
    logic [sti_pkg::ID_W-1:0]          cur_id;
    logic                              is_find;
    logic                              full;
    logic                              at_end;
    logic                              goes_before;
    logic                              hit;
    logic                              ins_write;

    assign idx_sel = idx_reg[sti_pkg::IDX_W-1:0];
    assign cur_key = keys_reg[idx_sel];
    assign cur_id  = ids_reg[idx_sel];

    assign is_find = (cmd_reg == sti_pkg::CMD_FIND);
    assign full    = (count_reg == sti_pkg::CNT_W'(sti_pkg::CAPACITY));
    assign at_end  = (idx_reg == count_reg);

    // The new entry goes in front of the first entry that sorts after it, so
    // it lands behind all entries with an equal key.
    assign goes_before = desc_reg ? (key_reg > cur_key) : (key_reg < cur_key);
    assign hit = !at_end && (is_find ? (cur_id == id_reg) : goes_before);

    assign stat.is_find = is_find;
    assign stat.full    = full;
    assign stat.at_end  = at_end;
    assign stat.hit     = hit;

    assign ins_write = ctl.commit && !is_find && !full;

    always_comb
    begin
        idx_next = idx_reg;
        if (ctl.load)
        begin
            idx_next = '0;
        end
        else if (ctl.advance)
        begin
            idx_next = idx_reg + sti_pkg::CNT_W'(1);
        end
    end

    assign count_next = ins_write ? (count_reg + sti_pkg::CNT_W'(1)) : count_reg;

    always_comb
    begin
        if (is_find)
        begin
            status_next = hit ? sti_pkg::ST_FOUND : sti_pkg::ST_NOT_FOUND;
        end
        else
        begin
            status_next = full ? sti_pkg::ST_FULL : sti_pkg::ST_INSERTED;
        end
        matched_key_next = (is_find && hit) ? cur_key : '0;
        entry_count_next = sti_pkg::COUNT_OUT_W'(count_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            count_reg <= '0;
            desc_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            count_reg <= count_next;
            done_reg  <= ctl.commit;
            if (cfg_wr)
            begin
                desc_reg <= cfg_descending;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg <= cmd;
            id_reg  <= item_id;
            key_reg <= sort_key;
        end
        if (ctl.commit)
        begin
            status_reg      <= status_next;
            matched_key_reg <= matched_key_next;
            entry_count_reg <= entry_count_next;
        end
    end

    // Each cell either takes the new entry, takes its left neighbor when the
    // insert opens a gap in front of it, or holds.
    for (genvar j = 0; j < sti_pkg::CAPACITY; j++)
    begin : g_cell
        if (j == 0)
        begin : g_head
            always_ff @(posedge clk)
            begin
                if (ins_write && (idx_reg == sti_pkg::CNT_W'(j)))
                begin
                    keys_reg[j] <= key_reg;
                    ids_reg[j]  <= id_reg;
                end
            end
        end
        else
        begin : g_body
            always_ff @(posedge clk)
            begin
                if (ins_write)
                begin
                    if (idx_reg == sti_pkg::CNT_W'(j))
                    begin
                        keys_reg[j] <= key_reg;
                        ids_reg[j]  <= id_reg;
                    end
                    else if ((sti_pkg::CNT_W'(j) > idx_reg) &&
                             (sti_pkg::CNT_W'(j) <= count_reg))
                    begin
                        keys_reg[j] <= keys_reg[j-1];
                        ids_reg[j]  <= ids_reg[j-1];
                    end
                end
            end
        end
    end

    assign done        = done_reg;
    assign status      = status_reg;
    assign matched_key = matched_key_reg;
    assign entry_count = entry_count_reg;

endmodule

@@ src/sorted_table_insert_find_top.sv @@
`timescale 1ns / 1ps
// Top level of the sorted table with insert and find by id.
// Depends on sti_pkg, sti_ctrl and sti_datapath.

// The block keeps up to 16 entries (id and signed key) in key order and
// takes one command at a time: raise start with cmd, item_id and sort_key
// while busy is low, and the command is taken at that clock edge. The
// controller then walks the table one entry per clock through a single
// read port and key/id comparator, and busy stays high until the scan
// stops at the deciding entry or runs past the n entries held, or at
// once for an insert into a full table. The result appears in the same
// cycle that busy goes low, and a new command can be taken in that
// same cycle. The result is shown for exactly one cycle, marked by
// done, and the receiver cannot stall it: status, matched_key and
// entry_count are valid only while done is high. An insert places the
// entry behind all entries with an equal key;
// a find returns the first entry in table order with the id. The order
// register (descending) is written through the cfg_valid / cfg_ready
// transaction, which is always ready; write it only while no command is
// in flight. Changing the order does not resort entries already held.
module sorted_table_insert_find_top (
    input  logic                              clk,
    input  logic                              rst_n,
    // Command channel.
    input  logic                              start,
    output logic                              busy,
    input  logic                              cmd,
    input  logic [sti_pkg::ID_W-1:0]          item_id,
    input  logic signed [sti_pkg::KEY_W-1:0]  sort_key,
    // Order register write channel.
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic                              descending,
    // Result channel.
    output logic                              done,
    output logic [sti_pkg::STATUS_W-1:0]      status,
    output logic signed [sti_pkg::KEY_W-1:0]  matched_key,
    output logic [sti_pkg::COUNT_OUT_W-1:0]   entry_count
);

    sti_pkg::sti_ctl_t  ctl;
    sti_pkg::sti_stat_t stat;

    // The order register has no side effects on a write, so the channel
    // completes a transaction in every cycle that valid is high.
    assign cfg_ready = 1'b1;

    sti_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .ctl   (ctl),
        .busy  (busy)
    );

    sti_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctl            (ctl),
        .stat           (stat),
        .cmd            (cmd),
        .item_id        (item_id),
        .sort_key       (sort_key),
        .cfg_wr         (cfg_valid && cfg_ready),
        .cfg_descending (descending),
        .done           (done),
        .status         (status),
        .matched_key    (matched_key),
        .entry_count    (entry_count)
    );

endmodule

@@ src/sti_checker.sv @@
`timescale 1ns / 1ps
// Port-level checker for the sorted table, bound to the top level.
// Depends on sti_pkg and sorted_table_insert_find_top.
module sti_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic                              busy,
    input  logic                              done,
    input  logic [sti_pkg::STATUS_W-1:0]      status,
    input  logic signed [sti_pkg::KEY_W-1:0]  matched_key,
    input  logic [sti_pkg::COUNT_OUT_W-1:0]   entry_count
);

    // A taken command keeps the block busy in the next cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("command taken but block not busy");

    // Exactly one result follows each command, in the cycle that busy falls.
    a_done_on_fall: assert property (@(posedge clk) disable iff (!rst_n)
        done == $fell(busy))
        else $error("result strobe out of step with busy");

    // Only a found entry reports a key.
    a_key_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status != sti_pkg::ST_FOUND)) |-> (matched_key == '0))
        else $error("key reported without a found entry");

    // A successful insert leaves at least one entry in the table.
    a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == sti_pkg::ST_INSERTED)) |-> (entry_count != '0))
        else $error("insert reported with an empty table");

    // A dropped insert is only reported with a full table.
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == sti_pkg::ST_FULL)) |->
        (entry_count == sti_pkg::COUNT_OUT_W'(sti_pkg::CAPACITY)))
        else $error("table full reported below capacity");

endmodule

bind sorted_table_insert_find_top sti_checker u_sti_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .done        (done),
    .status      (status),
    .matched_key (matched_key),
    .entry_count (entry_count)
);

@@ bench/sorted_table_checker.sv @@
`timescale 1ns / 1ps
// Checker for the sorted table. It watches the command, order-register and
// result channels, keeps its own copy of the table, and compares every result.
// Depends on sti_pkg.
module sorted_table_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic                              busy,
    input  logic                              cmd,
    input  logic [sti_pkg::ID_W-1:0]          item_id,
    input  logic signed [sti_pkg::KEY_W-1:0]  sort_key,
    input  logic                              cfg_valid,
    input  logic                              cfg_ready,
    input  logic                              descending,
    input  logic                              done,
    input  logic [sti_pkg::STATUS_W-1:0]      status,
    input  logic signed [sti_pkg::KEY_W-1:0]  matched_key,
    input  logic [sti_pkg::COUNT_OUT_W-1:0]   entry_count,
    output int                                errors,
    output int                                outstanding,
    output int                                n_placed,
    output int                                n_found,
    output int                                n_missed,
    output int                                n_dropped
);

    typedef struct packed {
        logic [sti_pkg::STATUS_W-1:0]     status;
        logic signed [sti_pkg::KEY_W-1:0] key;
        logic [sti_pkg::COUNT_OUT_W-1:0]  count;
    } table_reply_t;

    logic signed [sti_pkg::KEY_W-1:0] held_keys [sti_pkg::CAPACITY];
    logic [sti_pkg::ID_W-1:0]         held_ids  [sti_pkg::CAPACITY];
    int                               held_count;
    logic                             order_desc;
    table_reply_t                     pending_replies [$];

    // Applies one command to the local table and returns the reply it should give.
    function automatic table_reply_t apply_table_command(
        input logic                             c,
        input logic [sti_pkg::ID_W-1:0]         id,
        input logic signed [sti_pkg::KEY_W-1:0] k);
        table_reply_t r;
        int           slot;
        int           i;
        r.status = sti_pkg::ST_NOT_FOUND;
        r.key    = '0;
        if (c == sti_pkg::CMD_INSERT)
        begin
            if (held_count >= sti_pkg::CAPACITY)
            begin
                r.status = sti_pkg::ST_FULL;
            end
            else
            begin
                // Scanning from the back leaves slot at the first entry the key
                // must precede, so equal keys stay in arrival order.
                slot = held_count;
                for (i = held_count - 1; i >= 0; i--)
                begin
                    if (order_desc ? (k > held_keys[i]) : (k < held_keys[i]))
                        slot = i;
                end
                for (i = held_count; i > slot; i--)
                begin
                    held_keys[i] = held_keys[i-1];
                    held_ids[i]  = held_ids[i-1];
                end
                held_keys[slot] = k;
                held_ids[slot]  = id;
                held_count++;
                r.status = sti_pkg::ST_INSERTED;
            end
        end
        else
        begin
            for (i = held_count - 1; i >= 0; i--)
            begin
                if (held_ids[i] == id)
                begin
                    r.status = sti_pkg::ST_FOUND;
                    r.key    = held_keys[i];
                end
            end
        end
        r.count = sti_pkg::COUNT_OUT_W'(held_count);
        return r;
    endfunction

    task automatic report_mismatch(input table_reply_t want, input string why);
        errors++;
        if (errors <= 10)
            $display({"%0t: %s: expected status %0d key %0d count %0d, ",
                      "got status %0d key %0d count %0d"},
                     $realtime, why, want.status, want.key, want.count,
                     status, matched_key, entry_count);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        table_reply_t want;
        if (!rst_n)
        begin
            held_count  = 0;
            order_desc  = 1'b0;
            pending_replies.delete();
            errors      = 0;
            outstanding = 0;
            n_placed    = 0;
            n_found     = 0;
            n_missed    = 0;
            n_dropped   = 0;
        end
        else
        begin
            // A result leaving in the same cycle a new command is taken belongs
            // to the older command, so results are checked first.
            if (done)
            begin
                if (pending_replies.size() == 0)
                begin
                    want = '0;
                    report_mismatch(want, "result with no command outstanding");
                end
                else
                begin
                    want = pending_replies.pop_front();
                    if (status !== want.status || matched_key !== want.key ||
                        entry_count !== want.count)
                        report_mismatch(want, "result mismatch");
                    case (status)
                        sti_pkg::ST_INSERTED:  n_placed++;
                        sti_pkg::ST_FOUND:     n_found++;
                        sti_pkg::ST_NOT_FOUND: n_missed++;
                        default:               n_dropped++;
                    endcase
                end
            end
            if (cfg_valid && cfg_ready)
                order_desc = descending;
            if (start && !busy)
                pending_replies.push_back(apply_table_command(cmd, item_id, sort_key));
            outstanding = pending_replies.size();
        end
    end

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// Testbench top for the sorted table: clock, reset, command and order-register
// stimulus, and the final verdict. Depends on sti_pkg,
// sorted_table_insert_find_top and sorted_table_checker.
module tb_top;

    localparam logic signed [sti_pkg::KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
    localparam logic signed [sti_pkg::KEY_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;
    localparam int PHASES    = 5;
    localparam int PHASE_LEN = 210;

    logic                             clk;
    logic                             rst_n;
    logic                             start;
    logic                             busy;
    logic                             cmd;
    logic [sti_pkg::ID_W-1:0]         item_id;
    logic signed [sti_pkg::KEY_W-1:0] sort_key;
    logic                             cfg_valid;
    logic                             cfg_ready;
    logic                             descending;
    logic                             done;
    logic [sti_pkg::STATUS_W-1:0]     status;
    logic signed [sti_pkg::KEY_W-1:0] matched_key;
    logic [sti_pkg::COUNT_OUT_W-1:0]  entry_count;

    int errors;
    int outstanding;
    int n_placed;
    int n_found;
    int n_missed;
    int n_dropped;

    // Stimulus bookkeeping: ids sent with inserts, so that many finds hit.
    logic [sti_pkg::ID_W-1:0] inserted_ids [$];
    logic                     idle_on;
    int                       order_writes;

    sorted_table_insert_find_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .cmd         (cmd),
        .item_id     (item_id),
        .sort_key    (sort_key),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .descending  (descending),
        .done        (done),
        .status      (status),
        .matched_key (matched_key),
        .entry_count (entry_count)
    );

    sorted_table_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .cmd         (cmd),
        .item_id     (item_id),
        .sort_key    (sort_key),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .descending  (descending),
        .done        (done),
        .status      (status),
        .matched_key (matched_key),
        .entry_count (entry_count),
        .errors      (errors),
        .outstanding (outstanding),
        .n_placed    (n_placed),
        .n_found     (n_found),
        .n_missed    (n_missed),
        .n_dropped   (n_dropped)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Drives one command transaction. Every call starts at a falling edge, so
    // start is assigned once per edge: it stays high straight into the next
    // command, or drops only while an idle gap runs. The call returns right
    // after the rising edge that took the command.
    task automatic send_cmd(input logic c, input logic [sti_pkg::ID_W-1:0] id,
                            input logic signed [sti_pkg::KEY_W-1:0] k);
        int gap;
        @(negedge clk);
        if (idle_on && $urandom_range(0, 99) < 38)
        begin
            gap   = $urandom_range(1, 12);
            start = 1'b0;
            repeat (gap) @(negedge clk);
        end
        start    = 1'b1;
        cmd      = c;
        item_id  = id;
        sort_key = k;
        if (c == sti_pkg::CMD_INSERT)
        begin
            inserted_ids.push_back(id);
            if (inserted_ids.size() > 64)
                void'(inserted_ids.pop_front());
        end
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // Writes the order register with the block idle: commands stop, every
    // outstanding result is collected, and a full table scan's worth of
    // cycles passes before the write transaction.
    task automatic write_order(input logic desc);
        @(negedge clk);
        start = 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (sti_pkg::CAPACITY + 2) @(negedge clk);
        cfg_valid  = 1'b1;
        descending = desc;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b0;
        order_writes++;
    endtask

    initial
    begin
        int phase;
        int n;
        int pick;
        logic signed [sti_pkg::KEY_W-1:0] rand_key;
        logic [sti_pkg::ID_W-1:0]         rand_id;

        start        = 1'b0;
        cmd          = sti_pkg::CMD_INSERT;
        item_id      = '0;
        sort_key     = '0;
        cfg_valid    = 1'b0;
        descending   = 1'b0;
        rst_n        = 1'b0;
        idle_on      = 1'b1;
        order_writes = 0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        write_order(1'b0);

        // Ascending: a find on the empty table, the key extremes, an equal key
        // that must land behind the older entry, and a repeated id where the
        // find must report the first match in table order.
        send_cmd(sti_pkg::CMD_FIND,   16'h0000, $urandom);
        send_cmd(sti_pkg::CMD_INSERT, 16'h0001, 32'sd0);
        send_cmd(sti_pkg::CMD_INSERT, 16'hFFFF, KEY_MAX);
        send_cmd(sti_pkg::CMD_INSERT, 16'h0000, KEY_MIN);
        send_cmd(sti_pkg::CMD_INSERT, 16'h1234, 32'sd0);
        send_cmd(sti_pkg::CMD_INSERT, 16'h0001, -32'sd5);
        send_cmd(sti_pkg::CMD_FIND,   16'h0001, $urandom);
        send_cmd(sti_pkg::CMD_FIND,   16'hFFFF, $urandom);
        send_cmd(sti_pkg::CMD_FIND,   16'h0000, $urandom);
        send_cmd(sti_pkg::CMD_FIND,   16'hABCD, $urandom);

        // Switching to descending leaves the held entries where they are; new
        // inserts search the mixed table with the reversed comparison.
        write_order(1'b1);
        send_cmd(sti_pkg::CMD_INSERT, 16'h0002, 32'sd100);
        send_cmd(sti_pkg::CMD_INSERT, 16'h0003, KEY_MAX);
        send_cmd(sti_pkg::CMD_INSERT, 16'h0004, KEY_MIN);
        send_cmd(sti_pkg::CMD_INSERT, 16'h0005, -32'sd1);
        send_cmd(sti_pkg::CMD_FIND,   16'h0005, $urandom);

        // Back to ascending, fill the table to capacity, then push one more
        // insert into the full table and look entries up again.
        write_order(1'b0);
        send_cmd(sti_pkg::CMD_INSERT, 16'h0006, 32'sd0);
        send_cmd(sti_pkg::CMD_INSERT, 16'h0007, 32'sd0);
        send_cmd(sti_pkg::CMD_INSERT, 16'h8000, -32'sd5);
        send_cmd(sti_pkg::CMD_INSERT, 16'h5555, KEY_MAX);
        send_cmd(sti_pkg::CMD_INSERT, 16'hAAAA, 32'sh5555_5555);
        send_cmd(sti_pkg::CMD_INSERT, 16'h00FF, 32'shAAAA_AAAA);
        send_cmd(sti_pkg::CMD_INSERT, 16'h7FFF, 32'sd7);
        send_cmd(sti_pkg::CMD_INSERT, 16'h0009, 32'sd1);
        send_cmd(sti_pkg::CMD_FIND,   16'h0001, $urandom);
        send_cmd(sti_pkg::CMD_FIND,   16'h7FFF, $urandom);

        // Random phases. Most commands are finds, on ids already sent or on random
        // ids that mostly miss, with inserts (dropped once the table is full) mixed
        // in. One phase runs back to back; the order register flips between phases.
        for (phase = 0; phase < PHASES; phase++)
        begin
            idle_on = (phase != 2);
            for (n = 0; n < PHASE_LEN; n++)
            begin
                pick    = $urandom_range(0, 99);
                rand_id = sti_pkg::ID_W'($urandom);
                case ($urandom_range(0, 4))
                    0:       rand_key = KEY_MIN;
                    1:       rand_key = KEY_MAX;
                    2:       rand_key = $urandom_range(0, 8) - 4;
                    default: rand_key = $urandom;
                endcase
                if (pick < 45)
                    send_cmd(sti_pkg::CMD_FIND,
                             inserted_ids[$urandom_range(0, inserted_ids.size() - 1)],
                             $urandom);
                else if (pick < 70)
                    send_cmd(sti_pkg::CMD_FIND, rand_id, $urandom);
                else
                    send_cmd(sti_pkg::CMD_INSERT, rand_id, rand_key);
            end
            if (phase < PHASES - 1)
                write_order(phase[0] ? 1'b0 : 1'b1);
        end

        // Drain: stop commands, collect every result, then allow a full scan.
        @(negedge clk);
        start = 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (sti_pkg::CAPACITY + 4) @(negedge clk);

        $display("Covered %0d commands: %0d inserted, %0d found, %0d not found,",
                 n_placed + n_found + n_missed + n_dropped,
                 n_placed, n_found, n_missed);
        $display("%0d dropped on a full table; the order register took %0d writes.",
                 n_dropped, order_writes);
        if (errors == 0 && outstanding == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial
    begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

@@ sim.f @@
src/sti_pkg.sv
src/sti_ctrl.sv
src/sti_datapath.sv
src/sorted_table_insert_find_top.sv
src/sti_checker.sv
bench/sorted_table_checker.sv
bench/tb_top.sv
